// ===== sv/sidm_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the sorted id map
// no dependencies

package sidm_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_ID_WIDTH    = 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EXISTS  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic load;
        logic cmp;
        logic commit;
    } t_cmd;

endpackage

// ===== sv/sidm_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences capture, compare and commit of one item
// depends on sidm_pkg

module sidm_ctrl import sidm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    output logic o_s_ready,
    output logic o_m_valid,
    input  logic i_m_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    t_cmd       cmd;

    assign out_free   = !r_out_valid || i_m_ready;
    assign o_s_ready  = (r_state == S_IDLE) || ((r_state == S_EXEC) && out_free);
    assign cmd.load   = i_s_valid && o_s_ready;
    assign cmd.cmp    = (r_state == S_CMP);
    assign cmd.commit = (r_state == S_EXEC) && out_free;
    assign o_cmd      = cmd;
    assign o_m_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd.load) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = cmd.load ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_cmp_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_EXEC))
        else $error("compare not followed by execute");

    a_commit_sets_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> r_out_valid)
        else $error("commit did not present a result");

    a_no_commit_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_ready) |-> !cmd.commit)
        else $error("commit while result stalled");

endmodule

// ===== sv/sidm_datapath.sv =====
`timescale 1ns / 1ps
// datapath: sorted cell chain of key/value pairs, compare flags, result register
// depends on sidm_pkg

module sidm_datapath import sidm_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_op,
    input  logic [ID_WIDTH-1:0] i_src,
    input  logic [ID_WIDTH-1:0] i_loc,
    output logic [1:0]          o_status,
    output logic                o_found,
    output logic [ID_WIDTH-1:0] o_mapped
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic                r_op;
    logic [ID_WIDTH-1:0] r_src;
    logic [ID_WIDTH-1:0] r_loc;
    logic [ID_WIDTH-1:0] r_key [TABLE_DEPTH];
    logic [ID_WIDTH-1:0] r_val [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_eq;
    logic [TABLE_DEPTH-1:0] r_gt;
    logic [CW-1:0]       r_count;
    logic [1:0]          r_status, n_status;
    logic                r_found, n_found;
    logic [ID_WIDTH-1:0] r_mapped, n_mapped;

    logic                hit;
    logic                full;
    logic                do_insert;
    logic [ID_WIDTH-1:0] hit_val;

    assign full = (r_count == CW'(TABLE_DEPTH));
    assign hit  = |r_eq;

    always_comb begin
        hit_val = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit_val = hit_val | (r_val[i] & {ID_WIDTH{r_eq[i]}});
        end
    end

    always_comb begin
        n_status  = ST_OK;
        n_found   = 1'b0;
        n_mapped  = '0;
        do_insert = 1'b0;
        if (r_op == OP_LOOKUP) begin
            if (hit && (r_src != '0)) begin
                n_found  = 1'b1;
                n_mapped = hit_val;
            end
        end else if ((r_src == '0) || (r_loc == '0)) begin
            n_status = ST_INVALID;
        end else if (hit) begin
            n_status = ST_EXISTS;
        end else if (full) begin
            n_status = ST_FULL;
        end else begin
            do_insert = i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_src <= i_src;
            r_loc <= i_loc;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_mapped <= n_mapped;
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic valid;
        assign valid = (CW'(g) < r_count);

        always_ff @(posedge i_clk) begin
            if (i_cmd.cmp) begin
                r_eq[g] <= valid && (r_key[g] == r_src);
                r_gt[g] <= valid && (r_key[g] > r_src);
            end
        end

        if (g == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (do_insert && (r_gt[g] || (r_count == CW'(g)))) begin
                    r_key[g] <= r_src;
                    r_val[g] <= r_loc;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (do_insert) begin
                    if (r_gt[g-1]) begin
                        r_key[g] <= r_key[g-1];
                        r_val[g] <= r_val[g-1];
                    end else if (r_gt[g] || (r_count == CW'(g))) begin
                        r_key[g] <= r_src;
                        r_val[g] <= r_loc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_insert) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign o_status = r_status;
    assign o_found  = r_found;
    assign o_mapped = r_mapped;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> $stable(r_count))
        else $error("entry count moved without commit");

    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> $onehot0(r_eq))
        else $error("more than one matching key");

endmodule

// ===== sv/sorted_id_map.sv =====
`timescale 1ns / 1ps
// sorted id map: ordered table of source id to local id pairs
// depends on sidm_pkg, sidm_ctrl, sidm_datapath
//
// slave channel: one item is a lookup or an insert, opcode in tuser,
// source and local ids in tdata. every item gives exactly one result
// item on the master channel: status, found flag and mapped id.
// the table is a chain of sorted cells; all cells compare against the
// key together in the compare state, and the execute state commits the
// insert shift and loads the result register. a new item is accepted
// in the same cycle as the previous item commits, not during its compare.
// the result register decouples the sides: a new item is accepted
// while a result is still waiting, but its commit waits until the
// result register is free, so a stalled receiver holds the block.
// reset empties the table at once (entry count to zero) and drops any
// pending result; no clearing pass is needed.

module sorted_id_map import sidm_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH,
    localparam int IDW = ((2 * ID_WIDTH + 7) / 8) * 8,
    localparam int ODW = ((3 + ID_WIDTH + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [IDW-1:0] i_s_axis_tdata,  // source_id, local_id
    input  logic [0:0]     i_s_axis_tuser,  // opcode
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [ODW-1:0] o_m_axis_tdata   // status, found, mapped_id
);

    t_cmd                cmd;
    logic [1:0]          status;
    logic                found;
    logic [ID_WIDTH-1:0] mapped;

    sidm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (cmd)
    );

    sidm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_op     (i_s_axis_tuser[0]),
        .i_src    (i_s_axis_tdata[ID_WIDTH-1:0]),
        .i_loc    (i_s_axis_tdata[2*ID_WIDTH-1:ID_WIDTH]),
        .o_status (status),
        .o_found  (found),
        .o_mapped (mapped)
    );

    assign o_m_axis_tdata = ODW'({mapped, found, status});

endmodule

// ===== bench/sorted_id_map_checker.sv =====
`timescale 1ns / 1ps
// reply checker for the sorted id map: watches both stream channels, predicts
// every reply from its own copy of the id table and compares it field by field
// depends on sidm_pkg

module sorted_id_map_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // src_id, local_id
    input  logic [0:0]  i_s_tuser,   // opcode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // status, found, mapped_id
    output int          o_mismatches,
    output int          o_awaited
);
    import sidm_pkg::*;

    // lowest field last, so the struct overlays tdata from bit 0 up
    typedef struct packed {
        logic [31:0] mapped_id;
        logic        found;
        logic [1:0]  status;
    } t_reply;

    localparam int MAX_PRINTED = 40;

    logic [31:0] id_pairs [logic [31:0]];
    t_reply      awaited_replies [$];
    int          mismatches = 0;
    int          awaited = 0;
    int          reply_count = 0;

    assign o_mismatches = mismatches;
    assign o_awaited    = awaited;

    // ordering of the table never shows in a reply, so a keyed map is enough
    function automatic t_reply apply_map_op(input logic op, input logic [31:0] src,
                                            input logic [31:0] loc);
        t_reply r;
        r.status    = ST_OK;
        r.found     = 1'b0;
        r.mapped_id = '0;
        if (op == OP_LOOKUP) begin
            if (src != '0 && id_pairs.exists(src)) begin
                r.found     = 1'b1;
                r.mapped_id = id_pairs[src];
            end
        end else if (src == '0 || loc == '0) begin
            r.status = ST_INVALID;
        end else if (id_pairs.exists(src)) begin
            r.status = ST_EXISTS;
        end else if (id_pairs.num() >= DEF_TABLE_DEPTH) begin
            r.status = ST_FULL;
        end else begin
            id_pairs[src] = loc;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTED)
            $display("%0t ns: reply %0d %s: got %0h, expected %0h",
                     $time, reply_count, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            id_pairs.delete();
            awaited_replies.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_reply'(i_m_tdata[34:0]);
                if (awaited_replies.size() == 0) begin
                    report_mismatch("with nothing awaited, mapped_id", got.mapped_id, '0);
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.found != want.found)
                        report_mismatch("found", 32'(got.found), 32'(want.found));
                    if (got.mapped_id != want.mapped_id)
                        report_mismatch("mapped_id", got.mapped_id, want.mapped_id);
                end
                reply_count++;
            end
            if (i_s_tvalid && i_s_tready)
                awaited_replies.insert(awaited_replies.size(),
                                       apply_map_op(i_s_tuser[0], i_s_tdata[31:0],
                                                    i_s_tdata[63:32]));
        end
        awaited = awaited_replies.size();
    end

endmodule

// ===== bench/sorted_id_map_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the sorted id map: drives lookups and inserts with random
// gaps and receiver stalls, and gives the verdict from the reply checker
// depends on sidm_pkg, sorted_id_map, sorted_id_map_checker

module sorted_id_map_tb;
    import sidm_pkg::*;

    localparam int RANDOM_ITEMS   = 850;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // src_id, local_id
    logic [0:0]  s_tuser = '0;   // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // status, found, mapped_id
    int          mismatches;
    int          awaited;
    int          items_sent = 0;
    bit          hold_done = 1'b0;
    logic [31:0] known_keys [$];

    sorted_id_map uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    sorted_id_map_checker replies_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_mismatches (mismatches),
        .o_awaited    (awaited)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // window with no idling on either side
    function automatic bit in_burst();
        return items_sent >= 500 && items_sent < 600;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_id();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(1, 16);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return 32'h1 << $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [31:0] pick_known();
        if (known_keys.size() == 0) return rand_id();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    // new keys land anywhere in the order, often right beside a stored one
    function automatic logic [31:0] fresh_key();
        case ($urandom_range(0, 3))
            0, 1: return $urandom();
            2: return $urandom_range(0, 1) ? pick_known() + 32'd1 : pick_known() - 32'd1;
            default: return rand_id();
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [31:0] src, input logic [31:0] loc);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {loc, src};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        if (op == OP_INSERT && src != '0 && loc != '0)
            known_keys.insert(known_keys.size(), src);
        gap = in_burst() ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_item();
        int r;
        logic [31:0] src;
        logic [31:0] loc;
        r   = $urandom_range(0, 99);
        loc = rand_id();
        if (r < 35) begin
            send_item(OP_INSERT, fresh_key(), loc);
        end else if (r < 50) begin
            send_item(OP_INSERT, pick_known(), loc);
        end else if (r < 56) begin
            src = $urandom_range(0, 1) ? 32'd0 : fresh_key();
            send_item(OP_INSERT, src, (src == '0 && $urandom_range(0, 1)) ? loc : 32'd0);
        end else if (r < 88) begin
            send_item(OP_LOOKUP, pick_known(), $urandom());
        end else if (r < 96) begin
            send_item(OP_LOOKUP, fresh_key(), loc);
        end else begin
            send_item(OP_LOOKUP, 32'd0, $urandom());
        end
    endtask

    initial begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        // empty table
        send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // zero ids rejected
        send_item(OP_INSERT, 32'h0000_0000, 32'h0000_0005);
        send_item(OP_INSERT, 32'h0000_0007, 32'h0000_0000);
        send_item(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        // ordered inserts at both ends and in the middle
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(OP_INSERT, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_INSERT, 32'h0000_0002, 32'hAAAA_AAAA);
        send_item(OP_INSERT, 32'hFFFF_FFFE, 32'h5555_5555);
        // duplicate, and a zero local id on a stored key is invalid first
        send_item(OP_INSERT, 32'h0000_0001, 32'h0000_0009);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        // hits, misses, and local id ignored on lookup
        send_item(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h1234_5678);
        send_item(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        send_item(OP_LOOKUP, 32'h0000_0003, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 32'h0000_0002, 32'h0000_0000);
        send_item(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0001);
        send_item(OP_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
        repeat (RANDOM_ITEMS) random_item();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (awaited != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            if (!hold_done && items_sent >= 300) begin
                // long hold so the block fills and stalls its input
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end else if (in_burst()) begin
                m_tready <= 1'b1;
                @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sidm_pkg.sv
sv/sidm_ctrl.sv
sv/sidm_datapath.sv
sv/sorted_id_map.sv
bench/sorted_id_map_checker.sv
bench/sorted_id_map_tb.sv
